// ----- rtl/hsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants of the hop schedule deriver
// Holds the channel payload structs, the register index codes, the sequencer
// state encoding and the fixed timing constants of both schedule modes.
// ----------------------------------------------------------------------------
package hsd_pkg;

	// Input item: one slot's digest bytes plus the restart mark
	typedef struct packed {
		logic       restart;
		logic [7:0] jitter_byte;
		logic [7:0] channel_byte;
		logic [7:0] sync_byte_in;
	} hsd_in_t;

	// Result item: one schedule slot, or an empty slot once closed
	typedef struct packed {
		logic        slot_valid;
		logic [15:0] slot_time_ms;
		logic [7:0]  slot_channel;
		logic [7:0]  slot_sync_byte;
		logic [4:0]  slot_number;
		logic        schedule_closed;
	} hsd_out_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_WIDE_MODE         = 3'd0,
		CFG_CHANNEL_COUNT     = 3'd1,
		CFG_HAIL_CHANNEL      = 3'd2,
		CFG_NARROW_FIRST_MS   = 3'd3,
		CFG_NARROW_HORIZON_MS = 3'd4,
		CFG_WIDE_HORIZON_MS   = 3'd5
	} hsd_cfg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_JIT  = 5'b00010,
		S_CHAN = 5'b00100,
		S_TIME = 5'b01000,
		S_DONE = 5'b10000
	} hsd_state_t;

	// Timing constants, milliseconds
	localparam logic [16:0] WIDE_FIRST_MS   = 17'd150;
	localparam logic [7:0]  WIDE_JIT_MOD    = 8'd40;
	localparam logic [7:0]  NARROW_JIT_MOD  = 8'd24;
	localparam logic [9:0]  WIDE_STEP_BASE  = 10'd60;
	localparam logic [9:0]  WIDE_STEP_MAX   = 10'd350;
	localparam logic [9:0]  NARROW_STEP_MS  = 10'd100;

endpackage

// ----- rtl/hsd_stream_if.sv -----
// ----------------------------------------------------------------------------
// hsd_stream_if: valid/ready channel of the hop schedule deriver
// Carries one payload per transfer; a transfer happens at a rising clock edge
// with valid and ready both high.
// ----------------------------------------------------------------------------
interface hsd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/hop_schedule_deriver.sv -----
// ----------------------------------------------------------------------------
// hop_schedule_deriver: derives a hop schedule one slot at a time
// Each input transfer carries one slot's jitter, channel and sync bytes and
// gives exactly one result transfer: a slot, or an empty result once closed.
// ----------------------------------------------------------------------------
// Usage:
//   slot_in  (sink)   : restart, jitter_byte, channel_byte, sync_byte_in.
//   slot_out (source) : slot_valid, slot_time_ms, slot_channel,
//                       slot_sync_byte, slot_number, schedule_closed.
//   cfg_we/cfg_index/cfg_data : register writes, to be made by the user only while idle (not enforced by the block).
// Sequence: after the input transfer, one shared compare-subtract remainder
//   unit runs two passes of 8 steps (jitter mod 40 or 24, then channel byte mod
//   channel count), followed by a slot-time step and a closing-check step that
//   loads the result into the output register.
// Intake: slot_in.ready is high only while the sequencer is idle, and a new
//   item is taken while the last result still waits in the output register.
// Stall: a result that is not taken holds in the output register; a further
//   item then waits in its final cycle until the register frees.
// Reset: arst_n clears the config, sequencer and schedule state and drops any
//   held result; a first item without restart starts a fresh schedule.
// ----------------------------------------------------------------------------
module hop_schedule_deriver #(
	parameter int unsigned MAX_SLOTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hsd_stream_if.sink                       slot_in,
	hsd_stream_if.source                     slot_out,
	input  logic                             cfg_we,
	input  logic [hsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [5:0] MAX_SLOTS_W = 6'(MAX_SLOTS);

	// Configuration registers
	logic        wide_mode_q;
	logic [7:0]  chan_count_q;
	logic [7:0]  hail_chan_q;
	logic [15:0] narrow_first_q;
	logic [15:0] narrow_horizon_q;
	logic [15:0] wide_horizon_q;

	// Schedule state
	logic [16:0] running_time_q;
	logic [4:0]  slot_cnt_q;
	logic [7:0]  first_chan_q;
	logic        closed_q;

	// Sequencer and shared remainder unit
	hsd_pkg::hsd_state_t state_q;
	logic [2:0]          div_cnt_q;
	logic [7:0]          div_rem_q;
	logic [7:0]          div_dvd_q;
	logic [5:0]          jit_mod_q;
	logic [7:0]          chan_mod_q;
	logic [16:0]         time_q;
	hsd_pkg::hsd_in_t    item_q;

	// Output register
	logic             out_valid_q;
	hsd_pkg::hsd_out_t out_data_q;

	logic        in_xfer;
	logic        out_xfer;
	logic        out_load;
	logic        div_last;
	logic [7:0]  divisor;
	logic [8:0]  trial;
	logic        trial_ge;
	logic [7:0]  rem_next;
	logic [9:0]  step30;
	logic [9:0]  wide_step;
	logic [9:0]  base_step;
	logic [16:0] time_next;
	logic        closed_now;
	logic [15:0] horizon;
	logic        over_horizon;
	logic        slot_ok;
	logic [7:0]  chan_base;
	logic [7:0]  chan_alt;
	logic        chan_clash;
	logic [7:0]  chan_final;
	logic [5:0]  slot_inc;
	hsd_pkg::hsd_out_t out_next;

	assign in_xfer      = slot_in.valid && slot_in.ready;
	assign out_xfer     = slot_out.valid && slot_out.ready;
	assign slot_in.ready = (state_q == hsd_pkg::S_IDLE);
	assign slot_out.valid = out_valid_q;
	assign slot_out.data  = out_data_q;

	// Remainder step: shift in one dividend bit, subtract the divisor if it fits
	assign divisor  = (state_q == hsd_pkg::S_JIT) ?
		(wide_mode_q ? hsd_pkg::WIDE_JIT_MOD : hsd_pkg::NARROW_JIT_MOD) : chan_count_q;
	assign trial    = {div_rem_q, div_dvd_q[7]};
	assign trial_ge = (trial >= {1'b0, divisor});
	assign rem_next = trial_ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
	assign div_last = (div_cnt_q == 3'd7);

	// Slot time: first slot, or running time plus step plus jitter remainder
	assign step30    = 10'({slot_cnt_q, 5'b0}) - 10'({slot_cnt_q, 1'b0});
	assign wide_step = hsd_pkg::WIDE_STEP_BASE + step30;
	assign base_step = wide_mode_q ?
		((wide_step > hsd_pkg::WIDE_STEP_MAX) ? hsd_pkg::WIDE_STEP_MAX : wide_step) :
		hsd_pkg::NARROW_STEP_MS;

	always_comb begin
		if (slot_cnt_q == 5'd0) begin
			time_next = wide_mode_q ? (hsd_pkg::WIDE_FIRST_MS + 17'(jit_mod_q)) :
				{1'b0, narrow_first_q};
		end else begin
			time_next = running_time_q + 17'(base_step) + 17'(jit_mod_q);
		end
	end

	// Close checks and channel choice for the final cycle
	assign closed_now   = closed_q || ({1'b0, slot_cnt_q} >= MAX_SLOTS_W);
	assign horizon      = wide_mode_q ? wide_horizon_q : narrow_horizon_q;
	assign over_horizon = (time_q > {1'b0, horizon});
	assign slot_ok      = !closed_now && !over_horizon;
	assign slot_inc     = {1'b0, slot_cnt_q} + 6'd1;

	assign chan_base  = (chan_count_q != 8'd0) ? (chan_mod_q + 8'd1) : hail_chan_q;
	assign chan_alt   = ((chan_mod_q + 8'd1) == chan_count_q) ? 8'd1 : (chan_mod_q + 8'd2);
	assign chan_clash = !wide_mode_q && (slot_cnt_q == 5'd1) && (chan_count_q > 8'd1) &&
		(chan_base == first_chan_q);
	assign chan_final = chan_clash ? chan_alt : chan_base;

	always_comb begin
		out_next = '0;
		out_next.schedule_closed = 1'b1;
		if (slot_ok) begin
			out_next.slot_valid      = 1'b1;
			out_next.slot_time_ms    = time_q[15:0];
			out_next.slot_channel    = chan_final;
			out_next.slot_sync_byte  = item_q.sync_byte_in;
			out_next.slot_number     = slot_cnt_q;
			out_next.schedule_closed = (slot_inc >= MAX_SLOTS_W);
		end
	end

	assign out_load = (state_q == hsd_pkg::S_DONE) && (!out_valid_q || slot_out.ready);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q      <= 1'b0;
			chan_count_q     <= '0;
			hail_chan_q      <= '0;
			narrow_first_q   <= '0;
			narrow_horizon_q <= '0;
			wide_horizon_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsd_pkg::CFG_WIDE_MODE:         wide_mode_q      <= cfg_data[0];
				hsd_pkg::CFG_CHANNEL_COUNT:     chan_count_q     <= cfg_data[7:0];
				hsd_pkg::CFG_HAIL_CHANNEL:      hail_chan_q      <= cfg_data[7:0];
				hsd_pkg::CFG_NARROW_FIRST_MS:   narrow_first_q   <= cfg_data;
				hsd_pkg::CFG_NARROW_HORIZON_MS: narrow_horizon_q <= cfg_data;
				hsd_pkg::CFG_WIDE_HORIZON_MS:   wide_horizon_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, schedule state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= hsd_pkg::S_IDLE;
			div_cnt_q      <= '0;
			running_time_q <= '0;
			slot_cnt_q     <= '0;
			first_chan_q   <= '0;
			closed_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				hsd_pkg::S_IDLE: begin
					if (in_xfer) begin
						div_cnt_q <= '0;
						state_q   <= hsd_pkg::S_JIT;
						if (slot_in.data.restart) begin
							running_time_q <= '0;
							slot_cnt_q     <= '0;
							closed_q       <= 1'b0;
						end
					end
				end
				hsd_pkg::S_JIT: begin
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_last) begin
						state_q <= hsd_pkg::S_CHAN;
					end
				end
				hsd_pkg::S_CHAN: begin
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_last) begin
						state_q <= hsd_pkg::S_TIME;
					end
				end
				hsd_pkg::S_TIME: begin
					state_q <= hsd_pkg::S_DONE;
				end
				hsd_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= hsd_pkg::S_IDLE;
						if (slot_ok) begin
							running_time_q <= time_q;
							slot_cnt_q     <= slot_inc[4:0];
							closed_q       <= (slot_inc >= MAX_SLOTS_W);
							if (slot_cnt_q == 5'd0) begin
								first_chan_q <= chan_final;
							end
						end else begin
							closed_q <= 1'b1;
						end
					end
				end
				default: state_q <= hsd_pkg::S_IDLE;
			endcase
		end
	end

	// Datapath registers: item, remainder unit, slot time, result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q    <= slot_in.data;
			div_dvd_q <= slot_in.data.jitter_byte;
			div_rem_q <= '0;
		end
		if (state_q == hsd_pkg::S_JIT) begin
			if (div_last) begin
				jit_mod_q <= rem_next[5:0];
				div_dvd_q <= item_q.channel_byte;
				div_rem_q <= '0;
			end else begin
				div_dvd_q <= {div_dvd_q[6:0], 1'b0};
				div_rem_q <= rem_next;
			end
		end
		if (state_q == hsd_pkg::S_CHAN) begin
			div_dvd_q <= {div_dvd_q[6:0], 1'b0};
			div_rem_q <= rem_next;
			if (div_last) begin
				chan_mod_q <= rem_next;
			end
		end
		if (state_q == hsd_pkg::S_TIME) begin
			time_q <= time_next;
		end
		if (out_load) begin
			out_data_q <= out_next;
		end
	end

`ifndef SYNTHESIS
	// Slot count never runs past the limit
	a_slot_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_cnt_q} <= MAX_SLOTS_W)
		else $error("slot counter beyond slot limit");

	// A closed schedule stays closed until a restart item is taken
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q && !(in_xfer && slot_in.data.restart) |=> closed_q)
		else $error("schedule reopened without restart");

	// Running time only moves forward within a schedule
	a_time_forward: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_xfer && slot_in.data.restart) |=> running_time_q >= $past(running_time_q))
		else $error("running time went backward");

	// An empty result always reports the schedule closed
	a_empty_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.slot_valid |-> out_data_q.schedule_closed)
		else $error("empty result without closed flag");

	// A loaded slot carries the slot count it was built from
	a_slot_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && slot_ok |=> out_data_q.slot_number == $past(slot_cnt_q))
		else $error("slot number mismatch");
`endif

endmodule
